// ----- hdl/lh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lh_pkg: shared constants, types and bucket limit table
// Holds the bucket geometry, the command codes and the widths used by the
// latency histogram modules.
// ----------------------------------------------------------------------------
package lh_pkg;

    localparam int NUM_BUCKETS = 154;
    localparam int SAMPLE_BITS = 36;
    localparam int CNT_W       = 32;
    localparam int LIM_W       = 64;
    localparam int BIDX_W      = $clog2(NUM_BUCKETS);
    localparam int PH_W        = 14;
    localparam int NUM_W       = CNT_W + PH_W;            // target, num, den
    localparam int SUM_W       = CNT_W + PH_W + BIDX_W;   // cumulative count * 10000
    localparam int PROD_W      = LIM_W + NUM_W;
    localparam int REM_W       = NUM_W + 1;
    localparam int STEP_W      = $clog2(PROD_W + 1);

    localparam logic [PH_W-1:0] SCALE = PH_W'(10000);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef logic [LIM_W-1:0] t_lim_tab [NUM_BUCKETS];
    typedef logic [LIM_W-1:0] t_step_tab [16];

    localparam t_step_tab DECADE_STEPS = '{
        64'd12, 64'd14, 64'd16, 64'd18, 64'd20, 64'd25, 64'd30, 64'd35,
        64'd40, 64'd45, 64'd50, 64'd60, 64'd70, 64'd80, 64'd90, 64'd100
    };

    // Upper limit of every bucket; the last entry is never used as a bound.
    function automatic t_lim_tab f_limits();
        t_lim_tab   tab;
        int         j;
        logic [LIM_W-1:0] v;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (i < 10) begin
                tab[i] = LIM_W'(i + 1);
            end else begin
                j = i - 10;
                v = DECADE_STEPS[j % 16];
                for (int d = 0; d < j / 16; d++) begin
                    v = v * LIM_W'(10);
                end
                tab[i] = v;
            end
        end
        return tab;
    endfunction

    localparam t_lim_tab LIMITS = f_limits();

endpackage

// ----- hdl/lh_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lh_cell: one bucket counter of the histogram ring
// Counts samples that fall in its range and hands its count to the
// neighbor cell while the ring rotates.
// ----------------------------------------------------------------------------
module lh_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clr,
    input  logic                            i_shift,
    input  logic                            i_add,
    input  logic [lh_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic [lh_pkg::LIM_W-1:0]        i_lo,
    input  logic [lh_pkg::LIM_W-1:0]        i_hi,
    input  logic                            i_last,
    input  logic [lh_pkg::CNT_W-1:0]        i_next_count,
    output logic [lh_pkg::CNT_W-1:0]        o_count
);

    logic [lh_pkg::CNT_W-1:0] r_count;
    logic [lh_pkg::LIM_W-1:0] smp;
    logic                     hit;

    assign smp = lh_pkg::LIM_W'(i_sample);
    assign hit = (smp >= i_lo) && (i_last || smp < i_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_count <= '0;
        end else if (i_shift) begin
            r_count <= i_next_count;
        end else if (i_add && hit && r_count != '1) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_count = r_count;

endmodule

// ----- hdl/lh_muldiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lh_muldiv: serial floor(a * num / den)
// Shift-add multiply, one bit of a per cycle, then restoring division,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lh_muldiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lh_pkg::LIM_W-1:0]    i_a,
    input  logic [lh_pkg::NUM_W-1:0]    i_num,
    input  logic [lh_pkg::NUM_W-1:0]    i_den,
    output logic                        o_done,
    output logic [lh_pkg::LIM_W-1:0]    o_q
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [lh_pkg::STEP_W-1:0]    r_step;
    logic [lh_pkg::LIM_W-1:0]     r_a;
    logic [lh_pkg::NUM_W-1:0]     r_num;
    logic [lh_pkg::NUM_W-1:0]     r_den;
    logic [lh_pkg::PROD_W-1:0]    r_prod;
    logic [lh_pkg::REM_W-1:0]     r_rem;
    logic [lh_pkg::LIM_W-1:0]     r_q;
    logic [lh_pkg::REM_W-1:0]     n_rem;
    logic                         fits;

    assign n_rem = {r_rem[lh_pkg::REM_W-2:0], r_prod[lh_pkg::PROD_W-1]};
    assign fits  = n_rem >= lh_pkg::REM_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_prod  <= '0;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= (r_prod << 1)
                            + (r_a[lh_pkg::LIM_W-1] ? lh_pkg::PROD_W'(r_num) : '0);
                    r_a    <= r_a << 1;
                    if (r_step == lh_pkg::STEP_W'(lh_pkg::LIM_W - 1)) begin
                        r_step  <= '0;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem  <= fits ? n_rem - lh_pkg::REM_W'(r_den) : n_rem;
                    r_q    <= {r_q[lh_pkg::LIM_W-2:0], fits};
                    r_prod <= r_prod << 1;
                    if (r_step == lh_pkg::STEP_W'(lh_pkg::PROD_W - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_q    = r_q;

endmodule

// ----- hdl/latency_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram: log-linear latency histogram with percentile query
// Counts samples in a ring of bucket cells and answers percentile queries
// together with count, min, max, sum and sum of squares.
// ----------------------------------------------------------------------------
// An add beat first latches the sample, then in S_ADD the matching cell and
// the running statistics update. A clear beat and an unused command are
// handled in S_IDLE, which stays ready for the next beat. A query rotates
// the ring of cells once past the walk logic, one bucket per cycle, then a
// serial multiply and divide interpolate within the chosen bucket. A query
// that needs no interpolation skips the multiply and divide. The result sits
// in an output register, so the next beat is taken while a result still
// waits downstream. Only a new query stalls behind an untaken result.
// ----------------------------------------------------------------------------
module latency_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [35:0] i_sample,
    input  logic [13:0] i_percent_hundredths,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [35:0] o_percentile_value,
    output logic [31:0] o_sample_count,
    output logic [35:0] o_min_sample,
    output logic [35:0] o_max_sample,
    output logic [63:0] o_sample_sum,
    output logic [63:0] o_square_sum
);

    localparam int N = lh_pkg::NUM_BUCKETS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_WALK,
        S_CALC,
        S_MULDIV,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [lh_pkg::SAMPLE_BITS-1:0]  r_sample;
    logic [lh_pkg::NUM_W-1:0]        r_target;
    logic [lh_pkg::SUM_W-1:0]        r_sum10k;
    logic [lh_pkg::BIDX_W-1:0]       r_idx;
    logic                            r_found;
    logic [lh_pkg::BIDX_W-1:0]       r_b;
    logic [lh_pkg::NUM_W-1:0]        r_num;
    logic [lh_pkg::NUM_W-1:0]        r_den;
    logic [lh_pkg::LIM_W-1:0]        r_res;

    logic [lh_pkg::CNT_W-1:0]        r_total;
    logic [lh_pkg::SAMPLE_BITS-1:0]  r_min;
    logic [lh_pkg::SAMPLE_BITS-1:0]  r_max;
    logic [63:0]                     r_sum;
    logic [63:0]                     r_sqsum;

    logic [35:0]                     r_o_pct;
    logic [31:0]                     r_o_cnt;
    logic [35:0]                     r_o_min;
    logic [35:0]                     r_o_max;
    logic [63:0]                     r_o_sum;
    logic [63:0]                     r_o_sq;
    logic                            r_o_valid;

    logic [lh_pkg::CNT_W-1:0]        counts [N];
    logic                            accept;
    logic                            cell_clr;
    logic                            cell_shift;
    logic                            cell_add;

    // Walk datapath.
    logic [lh_pkg::CNT_W-1:0]        head;
    logic [lh_pkg::NUM_W-1:0]        head10k;
    logic [lh_pkg::SUM_W-1:0]        n_sum10k;
    logic                            reach;

    // Interpolation.
    logic [lh_pkg::LIM_W-1:0]        left;
    logic [lh_pkg::LIM_W-1:0]        width;
    logic                            last_b;
    logic                            md_start;
    logic                            md_done;
    logic [lh_pkg::LIM_W-1:0]        md_q;
    logic [lh_pkg::LIM_W-1:0]        interp;

    // Add datapath.
    logic [63:0]                     sq;
    logic [64:0]                     sum_ext;
    logic [64:0]                     sq_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign cell_clr   = accept && i_cmd == lh_pkg::CMD_CLEAR;
    assign cell_shift = (r_state == S_WALK);
    assign cell_add   = (r_state == S_ADD);

    // Ring of bucket cells; each hands its count to the one below while the
    // walk runs, and cell 0 feeds the walk logic.
    for (genvar g = 0; g < N; g++) begin : g_cell
        lh_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clr        (cell_clr),
            .i_shift      (cell_shift),
            .i_add        (cell_add),
            .i_sample     (r_sample),
            .i_lo         ((g == 0) ? '0 : lh_pkg::LIMITS[(g == 0) ? 0 : g - 1]),
            .i_hi         (lh_pkg::LIMITS[g]),
            .i_last       (g == N - 1),
            .i_next_count (counts[(g + 1) % N]),
            .o_count      (counts[g])
        );
    end

    assign head     = counts[0];
    assign head10k  = lh_pkg::NUM_W'(head) * lh_pkg::NUM_W'(lh_pkg::SCALE);
    assign n_sum10k = r_sum10k + lh_pkg::SUM_W'(head10k);
    assign reach    = !r_found && n_sum10k >= lh_pkg::SUM_W'(r_target);

    assign left   = (r_b == '0) ? '0 : lh_pkg::LIMITS[r_b - 1'b1];
    assign width  = lh_pkg::LIMITS[r_b] - left;
    assign last_b = (r_b == lh_pkg::BIDX_W'(N - 1));
    assign interp = left + md_q;

    assign md_start = (r_state == S_CALC) && r_found && !last_b && r_num != '0;

    lh_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (width),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    // Square saturates once the sample needs more than 32 bits.
    assign sq      = (r_sample[lh_pkg::SAMPLE_BITS-1:32] != '0) ? '1
                   : 64'(r_sample[31:0]) * 64'(r_sample[31:0]);
    assign sum_ext = {1'b0, r_sum} + 65'(r_sample);
    assign sq_ext  = {1'b0, r_sqsum} + {1'b0, sq};

    function automatic logic [lh_pkg::LIM_W-1:0] f_clamp(
        input logic [lh_pkg::LIM_W-1:0]       v,
        input logic [lh_pkg::SAMPLE_BITS-1:0] lo,
        input logic [lh_pkg::SAMPLE_BITS-1:0] hi
    );
        logic [lh_pkg::LIM_W-1:0] r;
        r = v;
        if (r < lh_pkg::LIM_W'(lo)) r = lh_pkg::LIM_W'(lo);
        if (r > lh_pkg::LIM_W'(hi)) r = lh_pkg::LIM_W'(hi);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_total   <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_sum     <= '0;
            r_sqsum   <= '0;
            r_found   <= 1'b0;
            r_idx     <= '0;
        end else begin
            // Drop the result once downstream takes it; in S_OUT the
            // output register is reloaded below instead.
            if (r_o_valid && i_out_ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= i_sample[lh_pkg::SAMPLE_BITS-1:0];
                        case (i_cmd)
                            lh_pkg::CMD_ADD: r_state <= S_ADD;
                            lh_pkg::CMD_QUERY: begin
                                r_target <= lh_pkg::NUM_W'(r_total)
                                          * lh_pkg::NUM_W'(i_percent_hundredths);
                                r_sum10k <= '0;
                                r_idx    <= '0;
                                r_found  <= 1'b0;
                                r_state  <= S_WALK;
                            end
                            lh_pkg::CMD_CLEAR: begin
                                r_total <= '0;
                                r_min   <= '1;
                                r_max   <= '0;
                                r_sum   <= '0;
                                r_sqsum <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD: begin
                    if (r_total != '1) r_total <= r_total + 1'b1;
                    if (r_sample < r_min) r_min <= r_sample;
                    if (r_sample > r_max) r_max <= r_sample;
                    r_sum   <= sum_ext[64] ? '1 : sum_ext[63:0];
                    r_sqsum <= sq_ext[64] ? '1 : sq_ext[63:0];
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    // Advance one bucket; capture the first one that reaches
                    // the threshold and keep rotating until the ring is home.
                    r_sum10k <= n_sum10k;
                    r_idx    <= r_idx + 1'b1;
                    if (reach) begin
                        r_found <= 1'b1;
                        r_b     <= r_idx;
                        r_num   <= (head == '0) ? '0
                                 : r_target - lh_pkg::NUM_W'(r_sum10k);
                        r_den   <= head10k;
                    end
                    if (r_idx == lh_pkg::BIDX_W'(N - 1)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (!r_found) begin
                        r_res   <= lh_pkg::LIM_W'(r_max);
                        r_state <= S_OUT;
                    end else if (last_b && r_num != '0) begin
                        r_res   <= lh_pkg::LIM_W'(r_max);
                        r_state <= S_OUT;
                    end else if (r_num == '0) begin
                        r_res   <= f_clamp(left, r_min, r_max);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MULDIV;
                    end
                end
                S_MULDIV: begin
                    if (md_done) begin
                        r_res   <= f_clamp(interp, r_min, r_max);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_pct   <= (r_total == '0) ? '0 : r_res[35:0];
                        r_o_cnt   <= r_total;
                        r_o_min   <= (r_total == '0) ? '0 : 36'(r_min);
                        r_o_max   <= (r_total == '0) ? '0 : 36'(r_max);
                        r_o_sum   <= r_sum;
                        r_o_sq    <= r_sqsum;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_percentile_value = r_o_pct;
    assign o_sample_count     = r_o_cnt;
    assign o_min_sample       = r_o_min;
    assign o_max_sample       = r_o_max;
    assign o_sample_sum       = r_o_sum;
    assign o_square_sum       = r_o_sq;

endmodule

// ----- hdl/lh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lh_checker: port-level checks for the latency histogram
// Watches the result channel and the relations between result fields.
// ----------------------------------------------------------------------------
module lh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [35:0] o_percentile_value,
    input  logic [31:0] o_sample_count,
    input  logic [35:0] o_min_sample,
    input  logic [35:0] o_max_sample
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_percentile_value))
        else $error("result dropped or changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sample_count == 32'd0 |->
            o_percentile_value == 36'd0 && o_min_sample == 36'd0 && o_max_sample == 36'd0)
        else $error("empty histogram gave nonzero statistics");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sample_count != 32'd0 |->
            o_min_sample <= o_percentile_value && o_percentile_value <= o_max_sample)
        else $error("percentile outside min and max");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind latency_histogram lh_checker u_lh_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_percentile_value (o_percentile_value),
    .o_sample_count     (o_sample_count),
    .o_min_sample       (o_min_sample),
    .o_max_sample       (o_max_sample)
);
